### src/sstdl_pkg.sv
// ----------------------------------------------------------------------------
// sstdl_pkg: shared definitions of the seven-segment time display link
// Field widths, register indexes, the result record and the segment table.
// ----------------------------------------------------------------------------
package sstdl_pkg;

  localparam int unsigned SecondsW = 16;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned NumDigits = 4;
  localparam int unsigned CfgIdxW  = 1;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_ADDRESS   = 1'b0,
    CFG_DISPLAY_CONTROL = 1'b1
  } cfg_idx_e;

  localparam logic [ByteW-1:0] StartAddressRst   = 8'b1100_0000;
  localparam logic [ByteW-1:0] DisplayControlRst = 8'b1000_1111;
  localparam logic [ByteW-1:0] ColonBit          = 8'h80;

  // One result transaction.
  typedef struct packed {
    logic clk_out;
    logic dio_out;
    logic dio_drive;
    logic busy_res;
    logic done_res;
  } res_t;

  typedef logic [NumDigits-1:0][ByteW-1:0] digits_t;

  // Seven-segment code of one decimal digit.
  function automatic logic [ByteW-1:0] seg_code(input logic [3:0] digit);
    logic [ByteW-1:0] code;
    case (digit)
      4'd0:    code = 8'h3f;
      4'd1:    code = 8'h06;
      4'd2:    code = 8'h5b;
      4'd3:    code = 8'h4f;
      4'd4:    code = 8'h66;
      4'd5:    code = 8'h6d;
      4'd6:    code = 8'h7d;
      4'd7:    code = 8'h07;
      4'd8:    code = 8'h7f;
      4'd9:    code = 8'h6f;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

### src/sstdl_if.sv
// ----------------------------------------------------------------------------
// sstdl_in_if / sstdl_out_if: valid/ready channels of the display link
// Input channel carries ticks and show requests, output channel the pin state.
// ----------------------------------------------------------------------------
interface sstdl_in_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [sstdl_pkg::SecondsW-1:0] seconds;
  logic                          dio_sample;

  modport source (output valid, output op, output seconds, output dio_sample,
                  input ready);
  modport sink   (input valid, input op, input seconds, input dio_sample,
                  output ready);
endinterface

interface sstdl_out_if;
  logic valid;
  logic ready;
  logic clk_out;
  logic dio_out;
  logic dio_drive;
  logic busy_res;
  logic done_res;

  modport source (output valid, output clk_out, output dio_out, output dio_drive,
                  output busy_res, output done_res, input ready);
  modport sink   (input valid, input clk_out, input dio_out, input dio_drive,
                  input busy_res, input done_res, output ready);
endinterface

### src/sstdl_time_conv.sv
// ----------------------------------------------------------------------------
// sstdl_time_conv: seconds to four seven-segment digit codes
// Five-stage pipeline using constant reciprocal multiplies; the result is held
// in the digit registers until the next conversion overwrites them.
// ----------------------------------------------------------------------------
module sstdl_time_conv (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [sstdl_pkg::SecondsW-1:0] seconds_i,
  output sstdl_pkg::digits_t             digits_o
);
  import sstdl_pkg::*;

  logic [4:0]          vld_q;
  logic [SecondsW-1:0] sec1_q, sec2_q;
  logic [10:0]         q2_q, q3_q;
  logic [5:0]          s3_q, s4_q;
  logic [3:0]          qh3_q;
  logic [6:0]          min4_q;
  logic [3:0]          mt4_q, st4_q;
  digits_t             digits_q;

  logic [31:0] q_prod;
  logic [10:0] q_d;
  logic [23:0] qh_prod;
  logic [3:0]  qh_d;
  logic [SecondsW-1:0] s_wide;
  logic [10:0] min_wide;
  logic [14:0] mt_prod, st_prod;
  logic [6:0]  mo_wide, so_wide;

  // Stage math: q = secs / 60, minutes = q mod 100, then tens and ones.
  always_comb begin
    q_prod   = 32'(sec1_q) * 32'd34953;
    q_d      = q_prod[31:21];
    s_wide   = sec2_q - SecondsW'(16'(q2_q) * 16'd60);
    qh_prod  = 24'(q2_q) * 24'd10486;
    qh_d     = qh_prod[23:20];
    min_wide = q3_q - 11'(11'(qh3_q) * 11'd100);
    mt_prod  = 15'(min4_q) * 15'd205;
    st_prod  = 15'(s4_q) * 15'd205;
    mo_wide  = min4_q - 7'(7'(mt4_q) * 7'd10);
    so_wide  = 7'(s4_q) - 7'(7'(st4_q) * 7'd10);
  end

  // Stage valid chain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], start_i};
    end
  end

  // Pipeline data registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sec1_q <= seconds_i;
    end
    if (vld_q[0]) begin
      q2_q   <= q_d;
      sec2_q <= sec1_q;
    end
    if (vld_q[1]) begin
      s3_q  <= s_wide[5:0];
      qh3_q <= qh_d;
      q3_q  <= q2_q;
    end
    if (vld_q[2]) begin
      min4_q <= min_wide[6:0];
      s4_q   <= s3_q;
    end
    if (vld_q[3]) begin
      mt4_q <= mt_prod[14:11];
      st4_q <= st_prod[14:11];
    end
    if (vld_q[4]) begin
      digits_q[0] <= seg_code(mt4_q);
      digits_q[1] <= seg_code(mo_wide[3:0]) | ColonBit;
      digits_q[2] <= seg_code(st4_q);
      digits_q[3] <= seg_code(so_wide[3:0]);
    end
  end

  assign digits_o = digits_q;

endmodule

### src/sstdl_link_seq.sv
// ----------------------------------------------------------------------------
// sstdl_link_seq: two-wire pin sequencer
// Steps the start/byte/acknowledge/stop sequence one pin change per processed
// tick, holding at the acknowledge wait, and reports the resulting pin levels.
// ----------------------------------------------------------------------------
module sstdl_link_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic                        op_i,
  input  logic                        dio_sample_i,
  input  logic [sstdl_pkg::ByteW-1:0] start_address_i,
  input  logic [sstdl_pkg::ByteW-1:0] display_control_i,
  input  sstdl_pkg::digits_t          digits_i,
  output logic                        conv_start_o,
  output sstdl_pkg::res_t             res_o
);
  import sstdl_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_S1A, ST_S1B, ST_S1C, ST_S2A, ST_S2B, ST_S2C, ST_S3A, ST_S3B,
    ST_S3C, ST_BCLKL, ST_BDIO, ST_BCLKH, ST_ACLKL, ST_AREL, ST_AWAIT,
    ST_ACLKL2, ST_ADRV, ST_PCLKL, ST_PDIOL, ST_PCLKH, ST_PDIOH
  } step_e;

  step_e            step_q, step_d;
  logic [ByteW-1:0] shift_q, shift_d;
  logic [2:0]       bit_q, bit_d;
  logic [2:0]       byte_q, byte_d;
  logic             clk_q, clk_d;
  logic             dio_q, dio_d;
  logic             drv_q, drv_d;
  logic             done_d;
  logic [ByteW-1:0] next_byte;
  logic [1:0]       digit_sel;

  // Byte to send for the current byte position.
  always_comb begin
    digit_sel = 2'(byte_q - 3'd1);
    if (byte_q == 3'd0) begin
      next_byte = start_address_i;
    end else if (byte_q <= 3'd4) begin
      next_byte = digits_i[digit_sel];
    end else begin
      next_byte = display_control_i;
    end
  end

  // Next-state logic for one tick or request.
  always_comb begin
    step_d  = step_q;
    shift_d = shift_q;
    bit_d   = bit_q;
    byte_d  = byte_q;
    clk_d   = clk_q;
    dio_d   = dio_q;
    drv_d   = drv_q;
    done_d  = 1'b0;
    conv_start_o = 1'b0;
    if (step_q == ST_IDLE) begin
      if (op_i) begin
        conv_start_o = step_i;
        bit_d  = '0;
        byte_d = '0;
        step_d = ST_S1A;
      end
    end else if (!op_i) begin
      unique case (step_q)
        ST_S1A, ST_S2A, ST_S3A: begin
          clk_d  = 1'b1;
          step_d = step_e'(step_q + 5'd1);
        end
        ST_S1B, ST_S2B, ST_S3B: begin
          dio_d  = 1'b1;
          step_d = step_e'(step_q + 5'd1);
        end
        ST_S1C: begin
          dio_d  = 1'b0;
          step_d = ST_S2A;
        end
        ST_S2C, ST_S3C: begin
          dio_d  = 1'b0;
          bit_d  = '0;
          step_d = ST_BCLKL;
        end
        ST_BCLKL: begin
          clk_d = 1'b0;
          if (bit_q == 3'd0) begin
            shift_d = next_byte;
          end
          step_d = ST_BDIO;
        end
        ST_BDIO: begin
          dio_d  = shift_q[bit_q];
          step_d = ST_BCLKH;
        end
        ST_BCLKH: begin
          clk_d = 1'b1;
          if (bit_q == 3'd7) begin
            bit_d  = '0;
            step_d = ST_ACLKL;
          end else begin
            bit_d  = bit_q + 3'd1;
            step_d = ST_BCLKL;
          end
        end
        ST_ACLKL: begin
          clk_d  = 1'b0;
          step_d = ST_AREL;
        end
        ST_AREL: begin
          drv_d  = 1'b0;
          step_d = ST_AWAIT;
        end
        ST_AWAIT: begin
          // Wait for the receiver to pull the data line low.
          if (!dio_sample_i) begin
            clk_d  = 1'b1;
            step_d = ST_ACLKL2;
          end
        end
        ST_ACLKL2: begin
          clk_d  = 1'b0;
          step_d = ST_ADRV;
        end
        ST_ADRV: begin
          drv_d = 1'b1;
          dio_d = 1'b0;
          if (byte_q == 3'd4) begin
            byte_d = 3'd5;
            step_d = ST_S3A;
          end else if (byte_q >= 3'd5) begin
            step_d = ST_PCLKL;
          end else begin
            byte_d = byte_q + 3'd1;
            step_d = ST_BCLKL;
          end
        end
        ST_PCLKL: begin
          clk_d  = 1'b0;
          step_d = ST_PDIOL;
        end
        ST_PDIOL: begin
          dio_d  = 1'b0;
          step_d = ST_PCLKH;
        end
        ST_PCLKH: begin
          clk_d  = 1'b1;
          step_d = ST_PDIOH;
        end
        ST_PDIOH: begin
          dio_d  = 1'b1;
          done_d = 1'b1;
          step_d = ST_IDLE;
        end
        default: begin
          step_d = ST_IDLE;
        end
      endcase
    end
  end

  // Sequencer state, updated once per processed transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= ST_IDLE;
      shift_q <= '0;
      bit_q   <= '0;
      byte_q  <= '0;
      clk_q   <= 1'b1;
      dio_q   <= 1'b1;
      drv_q   <= 1'b1;
    end else if (step_i) begin
      step_q  <= step_d;
      shift_q <= shift_d;
      bit_q   <= bit_d;
      byte_q  <= byte_d;
      clk_q   <= clk_d;
      dio_q   <= dio_d;
      drv_q   <= drv_d;
    end
  end

  // Pin levels after this transaction's update.
  always_comb begin
    res_o.clk_out   = clk_d;
    res_o.dio_out   = dio_d;
    res_o.dio_drive = drv_d;
    res_o.busy_res  = (step_d != ST_IDLE);
    res_o.done_res  = done_d;
  end

endmodule

### src/seven_segment_time_display_link.sv
// ----------------------------------------------------------------------------
// seven_segment_time_display_link: two-wire seven-segment clock display driver
// Bit-bangs a time value to a four-digit display, one pin change per tick.
// ----------------------------------------------------------------------------
// Usage: every input transaction yields exactly one output transaction that
// carries the clock and data line levels after that transaction. An input
// with op = 1 while idle loads a time in seconds and arms the sequence; each
// op = 0 transaction (a tick) then makes one pin change. dio_sample is looked
// at while the data line is released for an acknowledge; the sequence waits
// there until it reads low. Requests while busy are dropped.
// One input register and one result register lie between input acceptance and
// output valid, around a combinational sequencer step, and one transaction per
// cycle is sustained while the receiver keeps ready high. The digit conversion
// runs in a five-stage pipeline beside the sequencer and finishes long before
// the first digit byte goes out.
// When the receiver stalls, the result register holds and the input register
// takes one more transaction before ready falls. Reset leaves the block idle
// with both lines driven high and the configuration registers at 0xC0/0x8F.
// Configuration writes take effect at the next byte load.
// ----------------------------------------------------------------------------
module seven_segment_time_display_link (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  sstdl_in_if.sink                      in_i,
  sstdl_out_if.source                   out_o,
  input  logic                          cfg_we_i,
  input  logic [sstdl_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [sstdl_pkg::ByteW-1:0]   cfg_wdata_i
);
  import sstdl_pkg::*;

  logic                in_valid_q;
  logic                op_q;
  logic [SecondsW-1:0] seconds_q;
  logic                sample_q;
  logic                out_valid_q;
  res_t                res_q;
  res_t                res_d;
  logic                move;
  logic                conv_start;
  digits_t             digits;
  logic [ByteW-1:0]    start_address_q;
  logic [ByteW-1:0]    display_control_q;

  // A held transaction moves to the result register when that is free.
  assign move        = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || move;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_address_q   <= StartAddressRst;
      display_control_q <= DisplayControlRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_START_ADDRESS:   start_address_q   <= cfg_wdata_i;
        CFG_DISPLAY_CONTROL: display_control_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      op_q      <= in_i.op;
      seconds_q <= in_i.seconds;
      sample_q  <= in_i.dio_sample;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (move) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      res_q <= res_d;
    end
  end

  sstdl_time_conv u_conv (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (conv_start),
    .seconds_i (seconds_q),
    .digits_o  (digits)
  );

  sstdl_link_seq u_seq (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .step_i            (move),
    .op_i              (op_q),
    .dio_sample_i      (sample_q),
    .start_address_i   (start_address_q),
    .display_control_i (display_control_q),
    .digits_i          (digits),
    .conv_start_o      (conv_start),
    .res_o             (res_d)
  );

  assign out_o.valid     = out_valid_q;
  assign out_o.clk_out   = res_q.clk_out;
  assign out_o.dio_out   = res_q.dio_out;
  assign out_o.dio_drive = res_q.dio_drive;
  assign out_o.busy_res  = res_q.busy_res;
  assign out_o.done_res  = res_q.done_res;

  // Every processed transaction shows up as a result in the next cycle.
  a_move_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move |=> out_o.valid)
    else $error("processed transaction produced no result");

  // The data line is driven whenever no sequence is running.
  a_idle_driven: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.busy_res) |-> out_o.dio_drive)
    else $error("data line released while idle");

  // Completion leaves both lines high and the block idle.
  a_done_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.done_res) |->
      (!out_o.busy_res && out_o.clk_out && out_o.dio_out))
    else $error("stop condition completed with wrong line state");

  // An empty result register never blocks the input side.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled with empty result register");

endmodule
